[hw/rtl/hsw_pkg.sv]
// hsw_pkg: shared types, codes and helper functions of the stop-and-wait link
// used by every module of handshake_stop_and_wait_link; depends on nothing
`default_nettype none

package hsw_pkg;

    localparam int SEQ_BITS_DEF = 16;

    // result queue geometry
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // command codes
    localparam logic [2:0] CMD_CONNECT    = 3'd0;
    localparam logic [2:0] CMD_DISCONNECT = 3'd1;
    localparam logic [2:0] CMD_ACTION     = 3'd2;
    localparam logic [2:0] CMD_RX         = 3'd3;
    localparam logic [2:0] CMD_TICK       = 3'd4;

    // packet types
    localparam logic [7:0] TYPE_CONNECT = 8'h01;
    localparam logic [7:0] TYPE_ACTION  = 8'h02;
    localparam logic [7:0] TYPE_STATUS  = 8'h03;
    localparam logic [7:0] TYPE_CLOSE   = 8'h04;

    // completion codes
    localparam logic [1:0] DONE_ACKED  = 2'd0;
    localparam logic [1:0] DONE_NO_ACK = 2'd1;
    localparam logic [1:0] DONE_AHEAD  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SYN_MASK     = 2'd0;
    localparam logic [1:0] CFG_ACK_MASK     = 2'd1;
    localparam logic [1:0] CFG_NAK_MASK     = 2'd2;
    localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd3;

    localparam logic [7:0] SYN_MASK_RST     = 8'h01;
    localparam logic [7:0] ACK_MASK_RST     = 8'h02;
    localparam logic [7:0] NAK_MASK_RST     = 8'h04;
    localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd5;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  node_id;
        logic [7:0]  action_code;
        logic [7:0]  rx_type;
        logic [7:0]  rx_flags;
        logic [15:0] rx_seq;
        logic [31:0] rx_word;
    } item_t;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  dest;
        logic [7:0]  pkt_type;
        logic [7:0]  pkt_flags;
        logic [15:0] pkt_seq;
        logic [31:0] pkt_word;
        logic        done_valid;
        logic [1:0]  done_code;
        logic        last;
    } result_t;

    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    typedef struct packed {
        logic                 room;
        logic [RES_CNT_W-1:0] count;
    } fifo_stat_t;

    function automatic result_t make_pkt(logic [7:0] dest, logic [7:0] ptype,
                                         logic [7:0] flags, logic [15:0] seq,
                                         logic [31:0] word);
        result_t r;
        r            = '0;
        r.send_valid = 1'b1;
        r.dest       = dest;
        r.pkt_type   = ptype;
        r.pkt_flags  = flags;
        r.pkt_seq    = seq;
        r.pkt_word   = word;
        return r;
    endfunction

    function automatic result_t make_done(logic [1:0] code);
        result_t r;
        r            = '0;
        r.done_valid = 1'b1;
        r.done_code  = code;
        return r;
    endfunction

    function automatic logic [31:0] flip32(logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
        begin
            r[i] = v[31 - i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hsw_in_reg.sv]
// hsw_in_reg: input register that holds one accepted item for the link core
// depends on hsw_pkg
`default_nettype none

module hsw_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hsw_pkg::item_t in_item,
    input  wire logic           take,
    output logic                item_valid,
    output hsw_pkg::item_t      item
);

    logic           valid_reg;
    logic           valid_next;
    hsw_pkg::item_t item_reg;

    // free when empty or when the held item leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hsw_core.sv]
// hsw_core: link state, sequence and retry registers, configuration registers
// and the update logic that turns one item into up to two results; uses hsw_pkg
`default_nettype none

module hsw_core #(
    parameter int SEQ_BITS = hsw_pkg::SEQ_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [7:0]     cfg_data,
    input  wire logic           item_valid,
    input  wire hsw_pkg::item_t item,
    input  wire logic           room,
    output logic                take,
    output hsw_pkg::push_t      push,
    output hsw_pkg::result_t    res0,
    output hsw_pkg::result_t    res1
);

    typedef enum logic [1:0] {
        LINK_DISC = 2'd0,
        LINK_HAND = 2'd1,
        LINK_CONN = 2'd2
    } link_t;

    link_t               link_reg, link_next;
    logic [SEQ_BITS-1:0] seq_reg, seq_next;
    logic [7:0]          peer_reg, peer_next;
    logic                wait_reg, wait_next;
    logic [3:0]          att_reg, att_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [SEQ_BITS-1:0] pend_reg, pend_next;
    logic [7:0]          held_reg, held_next;

    logic [7:0] syn_mask_reg;
    logic [7:0] ack_mask_reg;
    logic [7:0] nak_mask_reg;
    logic [3:0] max_att_reg;

    // ack evaluation inputs and outcome
    logic [SEQ_BITS-1:0] rseq;
    logic [SEQ_BITS-1:0] taken_pend;
    logic                ev_pv;
    logic [SEQ_BITS-1:0] ev_pa;
    logic [3:0]          ev_att;
    logic [7:0]          ev_held;
    logic [SEQ_BITS-1:0] ack_val;
    logic [3:0]          lim;
    logic [3:0]          att_inc;
    logic                ev_close;
    logic                ev_match;
    hsw_pkg::result_t    ev_res;
    hsw_pkg::result_t    close_pkt;
    logic [7:0]          both_mask;

    assign cfg_ready = 1'b1;
    assign take      = item_valid && room;

    assign rseq       = SEQ_BITS'(item.rx_seq);
    assign taken_pend = (!pend_valid_reg || rseq > pend_reg) ? rseq : pend_reg;
    assign close_pkt  = hsw_pkg::make_pkt(peer_reg, hsw_pkg::TYPE_CLOSE, syn_mask_reg,
                                          16'd0, 32'd0);
    assign both_mask  = syn_mask_reg | ack_mask_reg;

    // what the evaluation sees depends on what the item did just before it
    always_comb
    begin
        ev_pv   = pend_valid_reg;
        ev_pa   = pend_reg;
        ev_att  = att_reg;
        ev_held = held_reg;
        if (item.cmd == hsw_pkg::CMD_RX)
        begin
            ev_pv = 1'b1;
            ev_pa = taken_pend;
        end
        else if (item.cmd == hsw_pkg::CMD_ACTION)
        begin
            ev_att  = 4'd0;
            ev_held = item.action_code;
        end
    end

    always_comb
    begin
        ack_val  = ev_pv ? ev_pa : '0;
        lim      = (max_att_reg == 4'd0) ? 4'd1 : max_att_reg;
        att_inc  = ev_att + 4'd1;
        ev_close = 1'b0;
        ev_match = 1'b0;
        priority if (ack_val > seq_reg)
        begin
            ev_close            = 1'b1;
            ev_res              = close_pkt;
            ev_res.done_valid   = 1'b1;
            ev_res.done_code    = hsw_pkg::DONE_AHEAD;
        end
        else if (ack_val == seq_reg)
        begin
            ev_match = 1'b1;
            ev_res   = hsw_pkg::make_done(hsw_pkg::DONE_ACKED);
        end
        else if (att_inc >= lim || att_inc == 4'd0)
        begin
            ev_close            = 1'b1;
            ev_res              = close_pkt;
            ev_res.done_valid   = 1'b1;
            ev_res.done_code    = hsw_pkg::DONE_NO_ACK;
        end
        else
        begin
            ev_res = hsw_pkg::make_pkt(peer_reg, hsw_pkg::TYPE_ACTION, 8'd0, 16'(seq_reg),
                                       {24'd0, ev_held});
        end
    end

    always_comb
    begin
        link_next       = link_reg;
        seq_next        = seq_reg;
        peer_next       = peer_reg;
        wait_next       = wait_reg;
        att_next        = att_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        held_next       = held_reg;
        res0            = '0;
        res1            = '0;
        push            = '0;

        // evaluation outcome, used by action, status and tick
        // its state effect is applied below, after the case, for items that evaluate
        unique case (item.cmd)
            hsw_pkg::CMD_CONNECT:
            begin
                if (link_reg == LINK_DISC)
                begin
                    peer_next  = item.node_id;
                    res0       = hsw_pkg::make_pkt(item.node_id, hsw_pkg::TYPE_CONNECT,
                                                   syn_mask_reg, 16'(seq_reg), 32'd0);
                    res0.last  = 1'b1;
                    push.first = 1'b1;
                    link_next  = LINK_HAND;
                    seq_next   = seq_reg + 1'b1;
                end
            end
            hsw_pkg::CMD_DISCONNECT:
            begin
                res0       = close_pkt;
                res0.last  = 1'b1;
                push.first = 1'b1;
                link_next  = LINK_DISC;
                seq_next   = '0;
                wait_next  = 1'b0;
                att_next   = 4'd0;
            end
            hsw_pkg::CMD_ACTION:
            begin
                if (!wait_reg)
                begin
                    held_next  = item.action_code;
                    wait_next  = 1'b1;
                    att_next   = 4'd0;
                    res0       = hsw_pkg::make_pkt(peer_reg, hsw_pkg::TYPE_ACTION, 8'd0,
                                                   16'(seq_reg), {24'd0, item.action_code});
                    push.first = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res1        = ev_res;
                        res1.last   = 1'b1;
                        push.second = 1'b1;
                    end
                    else
                    begin
                        res0.last = 1'b1;
                    end
                end
            end
            hsw_pkg::CMD_RX:
            begin
                if (item.rx_type == hsw_pkg::TYPE_CONNECT)
                begin
                    if (link_reg == LINK_HAND && (item.rx_flags & both_mask) == both_mask)
                    begin
                        res0       = hsw_pkg::make_pkt(peer_reg, hsw_pkg::TYPE_CONNECT,
                                                       ack_mask_reg, 16'd0,
                                                       hsw_pkg::flip32(item.rx_word));
                        res0.last  = 1'b1;
                        push.first = 1'b1;
                        link_next  = LINK_CONN;
                    end
                end
                else if (item.rx_type == hsw_pkg::TYPE_STATUS)
                begin
                    if ((item.rx_flags & nak_mask_reg) == 8'd0)
                    begin
                        pend_valid_next = 1'b1;
                        pend_next       = taken_pend;
                        if (wait_reg)
                        begin
                            res0       = ev_res;
                            res0.last  = 1'b1;
                            push.first = 1'b1;
                        end
                    end
                end
                else if (item.rx_type == hsw_pkg::TYPE_CLOSE)
                begin
                    seq_next  = '0;
                    link_next = LINK_DISC;
                    peer_next = 8'd0;
                    wait_next = 1'b0;
                    att_next  = 4'd0;
                end
            end
            hsw_pkg::CMD_TICK:
            begin
                if (wait_reg)
                begin
                    res0       = ev_res;
                    res0.last  = 1'b1;
                    push.first = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // state effect of an evaluation: it is the last result of the item
        if ((push.second) || (push.first && item.cmd != hsw_pkg::CMD_CONNECT
            && item.cmd != hsw_pkg::CMD_DISCONNECT && item.cmd != hsw_pkg::CMD_ACTION
            && !(item.cmd == hsw_pkg::CMD_RX && item.rx_type == hsw_pkg::TYPE_CONNECT)))
        begin
            pend_valid_next = 1'b0;
            pend_next       = '0;
            if (ev_close)
            begin
                link_next = LINK_DISC;
                seq_next  = '0;
                wait_next = 1'b0;
                att_next  = 4'd0;
            end
            else if (ev_match)
            begin
                seq_next  = seq_reg + 1'b1;
                wait_next = 1'b0;
                att_next  = 4'd0;
            end
            else
            begin
                att_next  = att_inc;
                wait_next = 1'b1;
            end
        end

        push.first  = push.first && take;
        push.second = push.second && take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg       <= LINK_DISC;
            seq_reg        <= '0;
            peer_reg       <= 8'd0;
            wait_reg       <= 1'b0;
            att_reg        <= 4'd0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            held_reg       <= 8'd0;
        end
        else if (take)
        begin
            link_reg       <= link_next;
            seq_reg        <= seq_next;
            peer_reg       <= peer_next;
            wait_reg       <= wait_next;
            att_reg        <= att_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            held_reg       <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            syn_mask_reg <= hsw_pkg::SYN_MASK_RST;
            ack_mask_reg <= hsw_pkg::ACK_MASK_RST;
            nak_mask_reg <= hsw_pkg::NAK_MASK_RST;
            max_att_reg  <= hsw_pkg::MAX_ATTEMPTS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hsw_pkg::CFG_SYN_MASK:     syn_mask_reg <= cfg_data;
                hsw_pkg::CFG_ACK_MASK:     ack_mask_reg <= cfg_data;
                hsw_pkg::CFG_NAK_MASK:     nak_mask_reg <= cfg_data;
                hsw_pkg::CFG_MAX_ATTEMPTS: max_att_reg  <= cfg_data[3:0];
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hsw_out_fifo.sv]
// hsw_out_fifo: small result queue that takes up to two results a cycle and
// hands out one; depends on hsw_pkg
`default_nettype none

module hsw_out_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire hsw_pkg::push_t   push,
    input  wire hsw_pkg::result_t res0,
    input  wire hsw_pkg::result_t res1,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output hsw_pkg::result_t      res,
    output hsw_pkg::fifo_stat_t   stat
);

    localparam int PW = hsw_pkg::RES_PTR_W;
    localparam int CW = hsw_pkg::RES_CNT_W;

    hsw_pkg::result_t slot_reg [hsw_pkg::RES_DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             pop;
    logic [PW-1:0]    tail_plus1;

    assign out_valid  = (count_reg != '0);
    assign res        = slot_reg[head_reg];
    assign pop        = out_valid && out_ready;
    assign tail_plus1 = tail_reg + 1'b1;

    // room for a two-result item, judged before this cycle's pop
    assign stat.room  = (count_reg <= CW'(hsw_pkg::RES_DEPTH - 2));
    assign stat.count = count_reg;

    always_comb
    begin
        head_next  = head_reg + PW'(pop);
        tail_next  = tail_reg + PW'(push.first) + PW'(push.second);
        count_next = count_reg + CW'(push.first) + CW'(push.second) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            slot_reg[tail_reg] <= res0;
        end
        if (push.second)
        begin
            slot_reg[tail_plus1] <= res1;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/handshake_stop_and_wait_link.sv]
// handshake_stop_and_wait_link: top level of the stop-and-wait link controller
// depends on hsw_pkg, hsw_in_reg, hsw_core and hsw_out_fifo
//
// usage:
//   in channel (in_valid/in_ready) carries one event item: connect, disconnect,
//   action, received packet or ack timeout tick. each item gives zero, one or
//   two results on the out channel (out_valid/out_ready); last marks the final
//   result of an item. an action sent while an ack is already pending gives two.
//   cfg channel (cfg_valid/cfg_ready, always ready) writes syn_mask, ack_mask,
//   nak_mask and max_attempts by index; write only while no item is in flight.
//   flow: an accepted item waits in the input register until the core takes it,
//   which needs queue room; its results are queued, then shown on the out ports.
//   throughput: one item per cycle while results are taken; the core works
//   whenever the 4-entry result queue has room for two results.
//   receiver stall: results wait in the queue; once it has less than two free
//   entries the input register holds its item and in_ready drops.
//   reset: link disconnected, sequence 0, no action waiting, no pending ack,
//   registers back to their defaults, queue empty.
`default_nettype none

module handshake_stop_and_wait_link #(
    parameter int SEQ_BITS = hsw_pkg::SEQ_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [7:0]  node_id,
    input  wire logic [7:0]  action_code,
    input  wire logic [7:0]  rx_type,
    input  wire logic [7:0]  rx_flags,
    input  wire logic [15:0] rx_seq,
    input  wire logic [31:0] rx_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             send_valid,
    output logic [7:0]       dest,
    output logic [7:0]       pkt_type,
    output logic [7:0]       pkt_flags,
    output logic [15:0]      pkt_seq,
    output logic [31:0]      pkt_word,
    output logic             done_valid,
    output logic [1:0]       done_code,
    output logic             last
);

    hsw_pkg::item_t      in_item;
    hsw_pkg::item_t      item;
    logic                item_valid;
    logic                take;
    hsw_pkg::push_t      push;
    hsw_pkg::result_t    res0;
    hsw_pkg::result_t    res1;
    hsw_pkg::result_t    res;
    hsw_pkg::fifo_stat_t stat;

    always_comb
    begin
        in_item.cmd         = cmd;
        in_item.node_id     = node_id;
        in_item.action_code = action_code;
        in_item.rx_type     = rx_type;
        in_item.rx_flags    = rx_flags;
        in_item.rx_seq      = rx_seq;
        in_item.rx_word     = rx_word;
    end

    hsw_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    hsw_core #(
        .SEQ_BITS (SEQ_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .room       (stat.room),
        .take       (take),
        .push       (push),
        .res0       (res0),
        .res1       (res1)
    );

    hsw_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res0      (res0),
        .res1      (res1),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res),
        .stat      (stat)
    );

    assign send_valid = res.send_valid;
    assign dest       = res.dest;
    assign pkt_type   = res.pkt_type;
    assign pkt_flags  = res.pkt_flags;
    assign pkt_seq    = res.pkt_seq;
    assign pkt_word   = res.pkt_word;
    assign done_valid = res.done_valid;
    assign done_code  = res.done_code;
    assign last       = res.last;

`ifndef ASSERT_OFF
    // a result that is not last always has its sibling queued behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> stat.count >= (hsw_pkg::RES_CNT_W)'(2))
        else $error("non-last result without a queued follower");

    // a failed action always closes the link with a close packet
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_valid && send_valid |-> pkt_type == hsw_pkg::TYPE_CLOSE)
        else $error("error completion without close packet");

    // a completion without a packet is only a successful ack
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_valid && !send_valid |-> done_code == hsw_pkg::DONE_ACKED)
        else $error("bare completion with error code");

    // the core never pushes a second result without a first
    assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first && take)
        else $error("second result pushed alone");
`endif

endmodule

`default_nettype wire
